// ===== rtl/pulse_width_timer_defines.svh =====
// ----------------------------------------------------------------------------
// Pulse width timer assertion macros
// Shared concurrent assertion macros for the pulse width timer modules. They
// compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_TIMER_DEFINES_SVH
`define PULSE_WIDTH_TIMER_DEFINES_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define PWT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pulse_width_timer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pulse_width_timer: next-cycle check failed");

`else

`define PWT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PWT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse width timer package
// Types, register indexes and constants shared by the pulse width timer.
// ----------------------------------------------------------------------------
package pwt_pkg;

  // Default width of the microsecond counter.
  localparam int unsigned PWT_COUNT_WIDTH = 32;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_US   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US = 2'd2;

  // Configuration reset values.
  localparam logic        RST_ACTIVE_LEVEL = 1'b1;
  localparam logic [31:0] RST_TIMEOUT_US   = 32'd0;
  localparam logic [7:0]  RST_TICKS_PER_US = 8'd240;

  // Timeout used when timeout_us is zero (ten seconds).
  localparam logic [31:0] DEFAULT_TIMEOUT_US = 32'd10_000_000;

  // Largest reportable pulse length.
  localparam logic [31:0] PULSE_MAX = 32'hFFFF_FFFF;

  // Current configuration, handed to the measurement core.
  typedef struct packed {
    logic        active_level;
    logic [31:0] timeout_us;
    logic [7:0]  ticks_per_us;
  } pwt_cfg_t;

  // One result transaction from the core to the output register.
  typedef struct packed {
    logic        valid;
    logic        timed_out;
    logic [31:0] pulse_us;
  } pwt_result_t;

  // Measurement phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE        = 4'b0001,
    PH_WAIT_IDLE   = 4'b0010,
    PH_WAIT_ACTIVE = 4'b0100,
    PH_MEASURE     = 4'b1000
  } pwt_phase_t;

endpackage

// ===== rtl/pwt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Pulse width timer configuration registers
// Holds active_level, timeout_us and ticks_per_us, written over the cfg port.
// ----------------------------------------------------------------------------
module pwt_cfg_regs
  import pwt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 cfg_ready,
  output pwt_cfg_t             cfg
);

  pwt_cfg_t cfg_r;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level <= RST_ACTIVE_LEVEL;
      cfg_r.timeout_us   <= RST_TIMEOUT_US;
      cfg_r.ticks_per_us <= RST_TICKS_PER_US;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACTIVE_LEVEL: cfg_r.active_level <= cfg_data[0];
        CFG_TIMEOUT_US:   cfg_r.timeout_us   <= cfg_data;
        CFG_TICKS_PER_US: cfg_r.ticks_per_us <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/pwt_core.sv =====
// ----------------------------------------------------------------------------
// Pulse width timer measurement core
// Phase machine, tick prescaler and saturating microsecond counter. Each
// accepted transaction updates the state and may produce one result.
// ----------------------------------------------------------------------------
`include "pulse_width_timer_defines.svh"

module pwt_core
  import pwt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = PWT_COUNT_WIDTH
)(
  input  logic        clk,
  input  logic        rst_n,
  input  pwt_cfg_t    cfg,
  input  logic        accept,
  input  logic        mode,
  input  logic        pin_level,
  output pwt_result_t res
);

  // Compare width covers both the counter and the 32-bit timeout.
  localparam int unsigned CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  pwt_phase_t             phase_r, phase_nxt;
  logic [7:0]             presc_r, presc_nxt;
  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt;

  logic [8:0]             presc_inc;
  logic [7:0]             div;
  logic                   us_wrap;
  logic [7:0]             presc_adv;
  logic [COUNT_WIDTH-1:0] elapsed_adv;
  logic [31:0]            limit;
  logic [CMP_W-1:0]       elapsed_ext;
  logic                   tmo;
  logic [31:0]            pulse_sat;
  logic                   idle_level;

  // Time advance for one tick: prescaler then saturating microsecond count.
  always_comb begin
    div       = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;
    presc_inc = {1'b0, presc_r} + 9'd1;
    us_wrap   = (presc_inc >= {1'b0, div});
    presc_adv = us_wrap ? 8'd0 : presc_inc[7:0];
    if (us_wrap && (elapsed_r != {COUNT_WIDTH{1'b1}})) begin
      elapsed_adv = elapsed_r + COUNT_WIDTH'(1);
    end else begin
      elapsed_adv = elapsed_r;
    end
  end

  // Timeout check and clamped pulse length, both on the advanced count.
  always_comb begin
    limit       = (cfg.timeout_us == 32'd0) ? DEFAULT_TIMEOUT_US : cfg.timeout_us;
    elapsed_ext = CMP_W'(elapsed_adv);
    tmo         = (elapsed_ext >= CMP_W'(limit));
    pulse_sat   = (elapsed_ext > CMP_W'(PULSE_MAX)) ? PULSE_MAX : elapsed_ext[31:0];
    idle_level  = ~cfg.active_level;
  end

  // Next state and result for the accepted transaction.
  always_comb begin
    phase_nxt   = phase_r;
    presc_nxt   = presc_r;
    elapsed_nxt = elapsed_r;
    res         = '0;
    if (accept) begin
      if (mode) begin
        phase_nxt   = PH_WAIT_IDLE;
        presc_nxt   = 8'd0;
        elapsed_nxt = '0;
      end else if (phase_r != PH_IDLE) begin
        presc_nxt   = presc_adv;
        elapsed_nxt = elapsed_adv;
        unique case (phase_r)
          PH_WAIT_IDLE: begin
            if (pin_level == idle_level) begin
              phase_nxt = PH_WAIT_ACTIVE;
            end else if (tmo) begin
              phase_nxt     = PH_IDLE;
              res.valid     = 1'b1;
              res.timed_out = 1'b1;
            end
          end
          PH_WAIT_ACTIVE: begin
            if (pin_level == cfg.active_level) begin
              // Pulse begins: restart both time counters.
              phase_nxt   = PH_MEASURE;
              presc_nxt   = 8'd0;
              elapsed_nxt = '0;
            end else if (tmo) begin
              phase_nxt     = PH_IDLE;
              res.valid     = 1'b1;
              res.timed_out = 1'b1;
            end
          end
          PH_MEASURE: begin
            if (pin_level == idle_level) begin
              phase_nxt    = PH_IDLE;
              res.valid    = 1'b1;
              res.pulse_us = pulse_sat;
            end else if (tmo) begin
              phase_nxt     = PH_IDLE;
              res.valid     = 1'b1;
              res.timed_out = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      presc_r   <= 8'd0;
      elapsed_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      presc_r   <= presc_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // A result only comes from an accepted tick transaction.
  `PWT_ASSERT_SAME(a_res_on_tick, clk, rst_n, res.valid, accept && !mode)
  // An idle timer ignores ticks.
  `PWT_ASSERT_SAME(a_idle_silent, clk, rst_n, (phase_r == PH_IDLE) && accept && !mode,
                   !res.valid)
  // Arming clears the counters and waits for the idle level.
  `PWT_ASSERT_NEXT(a_arm_clears, clk, rst_n, accept && mode,
                   (phase_r == PH_WAIT_IDLE) && (presc_r == 8'd0) && (elapsed_r == '0))

endmodule

// ===== rtl/pwt_out_reg.sv =====
// ----------------------------------------------------------------------------
// Pulse width timer output register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
`include "pulse_width_timer_defines.svh"

module pwt_out_reg
  import pwt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pwt_result_t res,
  input  logic        out_stall,
  output logic        busy,
  output logic        out_valid,
  output logic        out_timed_out,
  output logic [31:0] out_pulse_us
);

  logic        valid_r;
  logic        timed_out_r;
  logic [31:0] pulse_us_r;

  // Upstream must wait only while a held result is not being taken.
  assign busy = valid_r && out_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.valid) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      timed_out_r <= res.timed_out;
      pulse_us_r  <= res.pulse_us;
    end
  end

  assign out_valid     = valid_r;
  assign out_timed_out = timed_out_r;
  assign out_pulse_us  = pulse_us_r;

  // A held result is never overwritten.
  `PWT_ASSERT_SAME(a_no_overwrite, clk, rst_n, res.valid, !busy)
  // A timeout result reports a zero length.
  `PWT_ASSERT_NEXT(a_timeout_zero, clk, rst_n, res.valid && res.timed_out,
                   out_valid && out_timed_out && (out_pulse_us == 32'd0))

endmodule

// ===== rtl/pulse_width_timer.sv =====
// Output: a result is registered and presented in the cycle after the tick transaction that ends it.
// Throughput: one input transaction per cycle; the single output register only
// holds off input while a result waits under out_stall.
// Reset: synchronous active-low rst_n restores register defaults, idles the
// phase machine and empties the output register.
// ----------------------------------------------------------------------------
// Pulse width timer
// Measures one pulse on a sampled pin in whole microseconds, with timeout.
// ----------------------------------------------------------------------------
module pulse_width_timer
  import pwt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = PWT_COUNT_WIDTH
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic                 in_pin_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_timed_out,
  output logic [31:0]          out_pulse_us,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  pwt_cfg_t    cfg;
  pwt_result_t res;
  logic        busy;
  logic        accept;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  pwt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  pwt_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (accept),
    .mode      (in_mode),
    .pin_level (in_pin_level),
    .res       (res)
  );

  pwt_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .out_stall     (out_stall),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_timed_out (out_timed_out),
    .out_pulse_us  (out_pulse_us)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse width timer testbench
// Drives start and tick transactions into the timer, predicts every result
// in a scoreboard that mirrors the measurement phases, prescaler and timeout,
// and compares each result field by field. Directed pulses come first, then
// random pulse trains, broken trains and noise under many register settings,
// with random gaps on the input and back-pressure on the result channel.
// ----------------------------------------------------------------------------
module testbench;
  import pwt_pkg::*;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int unsigned ITEM_TARGET   = 1000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned STUCK_LIMIT   = 3000;
  localparam int unsigned DRAIN_CYCLES  = 4;

  typedef struct packed {
    logic        timed_out;
    logic [31:0] pulse_us;
  } pulse_result_t;

  // Scoreboard: tracks the timer state and holds the pulse results still due.
  class pulse_scoreboard;
    logic          level;
    logic [31:0]   timeout;
    logic [7:0]    tpu;
    pwt_phase_t    phase;
    logic [7:0]    prescale;
    logic [31:0]   elapsed_us;
    pulse_result_t pending_q[$];
    int unsigned   errors;
    int unsigned   effective;
    int unsigned   results;
    int unsigned   timeouts;

    function new();
      level      = RST_ACTIVE_LEVEL;
      timeout    = RST_TIMEOUT_US;
      tpu        = RST_TICKS_PER_US;
      phase      = PH_IDLE;
      prescale   = 8'd0;
      elapsed_us = 32'd0;
      errors     = 0;
      effective  = 0;
      results    = 0;
      timeouts   = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
      case (idx)
        CFG_ACTIVE_LEVEL: level   = data[0];
        CFG_TIMEOUT_US:   timeout = data;
        CFG_TICKS_PER_US: tpu     = data[7:0];
        default: ;
      endcase
    endfunction

    // Advance the measurement by one accepted input transaction.
    function void note_input(input logic mode, input logic pin);
      logic          idle_lvl;
      logic [7:0]    div;
      logic [31:0]   limit;
      pulse_result_t res;
      idle_lvl = ~level;
      if (mode == MODE_START) begin
        phase      = PH_WAIT_IDLE;
        prescale   = 8'd0;
        elapsed_us = 32'd0;
        effective++;
        return;
      end
      if (phase == PH_IDLE) return;
      effective++;

      // One clock tick of the prescaler; a zero divisor counts as one.
      div = (tpu == 8'd0) ? 8'd1 : tpu;
      if ({1'b0, prescale} + 9'd1 >= {1'b0, div}) begin
        prescale = 8'd0;
        if (elapsed_us != '1) elapsed_us = elapsed_us + 32'd1;
      end else begin
        prescale = prescale + 8'd1;
      end

      // Pin transitions take priority over the timeout on the same tick.
      limit = (timeout == 32'd0) ? DEFAULT_TIMEOUT_US : timeout;
      if (phase == PH_WAIT_IDLE && pin == idle_lvl) begin
        phase = PH_WAIT_ACTIVE;
      end else if (phase == PH_WAIT_ACTIVE && pin == level) begin
        phase      = PH_MEASURE;
        prescale   = 8'd0;
        elapsed_us = 32'd0;
      end else if (phase == PH_MEASURE && pin == idle_lvl) begin
        phase         = PH_IDLE;
        res.timed_out = 1'b0;
        res.pulse_us  = elapsed_us;
        pending_q.push_back(res);
      end else if (elapsed_us >= limit) begin
        phase         = PH_IDLE;
        res.timed_out = 1'b1;
        res.pulse_us  = 32'd0;
        pending_q.push_back(res);
      end
    endfunction

    task report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest pending one.
    task check_result(input logic t_out, input logic [31:0] width_us);
      pulse_result_t exp_res;
      results++;
      if (t_out) timeouts++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result timed_out=%0b pulse_us=%0d",
                                  t_out, width_us));
      end else begin
        exp_res = pending_q.pop_front();
        if (t_out !== exp_res.timed_out)
          report_mismatch($sformatf("result %0d timed_out=%0b, expected %0b",
                                    results, t_out, exp_res.timed_out));
        if (width_us !== exp_res.pulse_us)
          report_mismatch($sformatf("result %0d pulse_us=%0d, expected %0d",
                                    results, width_us, exp_res.pulse_us));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_mode;
  logic                 in_pin_level;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_timed_out;
  logic [31:0]          out_pulse_us;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  pulse_width_timer uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_pin_level (in_pin_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_timed_out(out_timed_out),
    .out_pulse_us (out_pulse_us),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pulse_scoreboard sb;
  logic            cur_level;
  bit              gapless;
  int unsigned     hold_left;
  int unsigned     settings;
  int unsigned     stuck_cycles;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Observe every handshake at the rising edge and watch for a hang.
  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_timed_out, out_pulse_us);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.note_input(in_mode, in_pin_level);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (moved) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("Watchdog expired after %0d cycles without a transaction.", stuck_cycles);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Result back-pressure: random stall segments, plus a long hold on request.
  initial begin : receiver
    int unsigned seg_left;
    int unsigned r;
    out_stall = 1'b0;
    seg_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
        seg_left = 0;
      end else if (seg_left > 0) begin
        seg_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          out_stall <= 1'b1;
          seg_left = (r < 30) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end else begin
          out_stall <= 1'b0;
          seg_left = (r < 90) ? $urandom_range(0, 20) : $urandom_range(50, 150);
        end
      end
    end
  end

  // Random idle cycles after a transaction, mostly short.
  task automatic pause_sender();
    int unsigned r;
    int unsigned n;
    if (gapless) return;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_item(input logic mode, input logic pin);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_pin_level <= pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pause_sender();
  endtask

  // Stop offering input and wait until every pending result has arrived.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Program all three registers while the timer is quiet. Unused upper data
  // bits carry random values, which the timer must ignore.
  task automatic apply_setting(input logic level, input logic [31:0] tmo,
                               input logic [7:0] ticks);
    logic [31:0] word;
    settle();
    word    = $urandom();
    word[0] = level;
    program_reg(CFG_ACTIVE_LEVEL, word);
    program_reg(CFG_TIMEOUT_US, tmo);
    word      = $urandom();
    word[7:0] = ticks;
    program_reg(CFG_TICKS_PER_US, word);
    cur_level = level;
    settings++;
  endtask

  // A start followed by a pulse on the pin; a truncated train stops early.
  task automatic pulse_train(input bit truncate);
    int unsigned lead;
    int unsigned idle_n;
    int unsigned width;
    int unsigned total;
    int unsigned cut;
    int unsigned step;
    logic        pin;
    lead   = $urandom_range(0, 2);
    idle_n = $urandom_range(1, 3);
    width  = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 300) : $urandom_range(1, 20);
    total  = lead + idle_n + width;
    cut    = truncate ? $urandom_range(1, total) : total + 1;
    send_item(MODE_START, 1'($urandom_range(0, 1)));
    for (step = 0; step < cut; step++) begin
      if (step < lead) pin = 1'($urandom_range(0, 1));
      else if (step < lead + idle_n) pin = ~cur_level;
      else if (step < total) pin = cur_level;
      else pin = ~cur_level;
      send_item(MODE_TICK, pin);
    end
  endtask

  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(1, 12);
    repeat (n) begin
      send_item(($urandom_range(0, 7) == 0) ? MODE_START : MODE_TICK,
                1'($urandom_range(0, 1)));
    end
  endtask

  // Main stimulus.
  initial begin : stimulus
    int unsigned phase_no;
    int unsigned r;
    int unsigned n_seq;
    logic        level;
    logic [31:0] tmo;
    logic [7:0]  ticks;
    bit          hold;

    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = MODE_TICK;
    in_pin_level = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_ACTIVE_LEVEL;
    cfg_data     = 32'd0;
    cur_level    = RST_ACTIVE_LEVEL;
    gapless      = 1'b0;
    hold_left    = 0;
    settings     = 1;
    stuck_cycles = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a pulse much shorter than one microsecond measures zero.
    send_item(MODE_START, 1'b0);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_TICK, 1'b0);

    // One tick per microsecond, timeout of three.
    apply_setting(1'b1, 32'd3, 8'd1);
    // A tick while idle is ignored.
    send_item(MODE_TICK, 1'b1);
    // The pulse ends on the tick that reaches the timeout: the pulse wins.
    send_item(MODE_START, 1'b1);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_TICK, 1'b0);
    // The pin never returns to idle, so the wait for idle times out.
    send_item(MODE_START, 1'b0);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_TICK, 1'b1);
    // A second start abandons a running measurement.
    send_item(MODE_START, 1'b0);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_START, 1'b1);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_TICK, 1'b0);

    // Active-low pulse, zero prescaler and the largest timeout.
    apply_setting(1'b0, 32'hFFFF_FFFF, 8'd0);
    program_reg(CFG_UNUSED, $urandom());
    send_item(MODE_START, 1'b1);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b1);

    // Random phases, each under a fresh register setting.
    phase_no = 0;
    while (sb.effective < ITEM_TARGET) begin
      phase_no++;
      level = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 45) ticks = 8'($urandom_range(1, 3));
      else if (r < 75) ticks = 8'($urandom_range(4, 16));
      else if (r < 85) ticks = 8'd255;
      else if (r < 92) ticks = RST_TICKS_PER_US;
      else if (r < 96) ticks = 8'd0;
      else ticks = 8'($urandom_range(17, 254));
      r = $urandom_range(0, 99);
      if (r < 35) tmo = $urandom_range(1, 8);
      else if (r < 65) tmo = $urandom_range(9, 60);
      else if (r < 78) tmo = 32'd0;
      else if (r < 88) tmo = 32'hFFFF_FFFF;
      else tmo = $urandom();

      // Some phases hold the result side off while results come quickly.
      hold = (phase_no % 5 == 1);
      if (hold) begin
        ticks = 8'($urandom_range(1, 2));
        tmo   = $urandom_range(5, 30);
      end
      apply_setting(level, tmo, ticks);
      gapless = ($urandom_range(0, 3) == 0);
      if (hold) hold_left = HOLD_CYCLES;

      n_seq = $urandom_range(4, 12);
      repeat (n_seq) begin
        r = $urandom_range(0, 99);
        if (r < 70) pulse_train(1'b0);
        else if (r < 85) pulse_train(1'b1);
        else noise_burst();
      end
    end

    gapless = 1'b0;
    settle();
    repeat (10) @(posedge clk);

    $display("Checked %0d input transactions and %0d results (%0d timeouts) under %0d settings.",
             sb.effective, sb.results, sb.timeouts, settings);
    $display("Run included long result holds, drained pauses and extreme prescaler values.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pwt_pkg.sv
rtl/pwt_cfg_regs.sv
rtl/pwt_core.sv
rtl/pwt_out_reg.sv
rtl/pulse_width_timer.sv
sim/testbench.sv
